@@ design/tscw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tscw_pkg: shared constants for the text screen cell writer
// Command codes, special character codes and the fixed field widths of the
// stream words.
// ----------------------------------------------------------------------------
package tscw_pkg;

  // Field widths of the stream words.
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned IN_DW   = 24;
  localparam int unsigned OUT_DW  = 24;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLR_ALL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLR_BOT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

  // Character codes with a special meaning.
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] CH_EMPTY   = 8'd0;

  // Tab stops sit on multiples of this step.
  localparam int unsigned TAB_STEP = 8;

endpackage : tscw_pkg
`default_nettype wire

@@ design/text_screen_cell_writer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_screen_cell_writer: character cell store with a cursor
// Keeps a ROWS x COLUMNS store of 8-bit cells in one synchronous memory and
// a cursor; executes put, move, clear and read commands one word at a time.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Port group   Contents
// -------   ---------  ----------   ---------------------------------------
// command   in         s_axis_*     tuser: command; tdata: char, row, column
// result    out        m_axis_*     tdata: cursor row, cursor column, cell
//
// A put of an ordinary character and a read each pass through a second state
// (ST_FILL or ST_READ) before their result; a move or an unused command
// finishes in the state that takes it. A newline, a tab and the two clear
// commands write a run of cells, because the single memory write port writes
// one cell per cycle. After reset the block sweeps every cell to zero,
// one cell per cycle, and accepts no word until the sweep is done. A result
// that cannot leave because the output register is still full holds the
// block until the output register frees up; a stalled result side never
// loses or repeats a word.
//
module text_screen_cell_writer
  import tscw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Command side.
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: char_code [7:0], row [12:8], column [19:13], zero fill above.
  input  wire logic [IN_DW-1:0]  s_axis_tdata,
  // tuser: command [2:0].
  input  wire logic [CMD_W-1:0]  s_axis_tuser,
  // Result side.
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // tdata: cursor_row_out [4:0], cursor_column_out [11:5],
  // cell_value [19:12], zero fill above.
  output logic [OUT_DW-1:0]      m_axis_tdata
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CW    = $clog2(COLUMNS);

  // Sequencer states.
  localparam logic [2:0] ST_INIT = 3'd0;  // clearing sweep after reset
  localparam logic [2:0] ST_IDLE = 3'd1;  // ready for a command word
  localparam logic [2:0] ST_FILL = 3'd2;  // writing a run of cells
  localparam logic [2:0] ST_READ = 3'd3;  // memory read data arriving
  localparam logic [2:0] ST_DONE = 3'd4;  // result waits for the output

  logic [2:0]        state_q, state_d;
  logic [RW-1:0]     cur_row_q, cur_row_d;
  logic [CW-1:0]     cur_col_q, cur_col_d;
  logic [AW-1:0]     fill_addr_q, fill_addr_d;
  logic [AW-1:0]     fill_last_q, fill_last_d;
  logic [CHAR_W-1:0] fill_val_q, fill_val_d;
  logic [CHAR_W-1:0] pend_val_q, pend_val_d;

  logic              out_valid_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  logic [CHAR_W-1:0] out_cell_q;

  // The cell store and its registered read port.
  logic [CHAR_W-1:0] mem [CELLS];
  logic [CHAR_W-1:0] rd_data_q;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     rd_addr;

  // Fields of the incoming word.
  logic [CMD_W-1:0]  in_cmd;
  logic [CHAR_W-1:0] in_char;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;

  assign in_cmd  = s_axis_tuser;
  assign in_char = s_axis_tdata[7:0];
  assign in_row  = s_axis_tdata[12:8];
  assign in_col  = s_axis_tdata[19:13];

  logic s_fire;
  logic out_free;
  logic out_load;
  logic done_now;
  logic [CHAR_W-1:0] out_val;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Addresses derived from the cursor. The cursor is always on screen, so
  // its linear address never leaves the store.
  logic [AW-1:0] row_base;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] row_end;
  logic          last_row;

  assign row_base = AW'(AW'(cur_row_q) * AW'(COLUMNS));
  assign cur_addr = row_base + AW'(cur_col_q);
  assign row_end  = row_base + AW'(COLUMNS - 1);
  assign last_row = (cur_row_q == RW'(ROWS - 1));

  // Tab span: up to the next multiple of the tab step, cut at the row end.
  logic [3:0]    tab_len;
  logic [CW:0]   tab_end;
  logic          tab_wraps;
  logic [AW-1:0] tab_last;

  assign tab_len   = 4'(TAB_STEP) - {1'b0, cur_col_q[2:0]};
  assign tab_end   = (CW + 1)'(cur_col_q) + (CW + 1)'(tab_len);
  assign tab_wraps = (tab_end >= (CW + 1)'(COLUMNS));
  assign tab_last  = cur_addr + AW'(tab_len - 4'd1);

  // Clamped coordinates of a move or read.
  logic [RW-1:0] clamp_row;
  logic [CW-1:0] clamp_col;

  assign clamp_row = (32'(in_row) >= 32'(ROWS))    ? RW'(ROWS - 1)    : RW'(in_row);
  assign clamp_col = (32'(in_col) >= 32'(COLUMNS)) ? CW'(COLUMNS - 1) : CW'(in_col);
  assign rd_addr   = AW'(AW'(clamp_row) * AW'(COLUMNS)) + AW'(clamp_col);

  always_comb begin
    state_d     = state_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    fill_addr_d = fill_addr_q;
    fill_last_d = fill_last_q;
    fill_val_d  = fill_val_q;
    pend_val_d  = pend_val_q;
    out_val     = pend_val_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    done_now    = 1'b0;

    case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        if (fill_addr_q == fill_last_q) begin
          state_d = ST_IDLE;
        end else begin
          fill_addr_d = fill_addr_q + AW'(1);
        end
      end

      ST_IDLE: begin
        if (s_fire) begin
          pend_val_d = CH_EMPTY;
          out_val    = CH_EMPTY;
          case (in_cmd)
            CMD_PUT: begin
              state_d     = ST_FILL;
              fill_addr_d = cur_addr;
              if (in_char == CH_NEWLINE) begin
                // Clear the rest of the row, then go to the next row unless on the bottom row.
                fill_last_d = row_end;
                fill_val_d  = CH_EMPTY;
                if (!last_row) begin
                  cur_row_d = cur_row_q + RW'(1);
                  cur_col_d = '0;
                end
              end else if (in_char == CH_TAB) begin
                fill_val_d = CH_SPACE;
                if (tab_wraps) begin
                  fill_last_d = row_end;
                  if (!last_row) begin
                    cur_row_d = cur_row_q + RW'(1);
                    cur_col_d = '0;
                  end else begin
                    // The bottom row keeps the cursor on its last column.
                    cur_col_d = CW'(COLUMNS - 1);
                  end
                end else begin
                  fill_last_d = tab_last;
                  cur_col_d   = CW'(tab_end);
                end
              end else begin
                fill_last_d = cur_addr;
                fill_val_d  = in_char;
                if (cur_col_q == CW'(COLUMNS - 1)) begin
                  if (!last_row) begin
                    cur_row_d = cur_row_q + RW'(1);
                    cur_col_d = '0;
                  end
                end else begin
                  cur_col_d = cur_col_q + CW'(1);
                end
              end
            end
            CMD_MOVE: begin
              cur_row_d = clamp_row;
              cur_col_d = clamp_col;
              done_now  = 1'b1;
            end
            CMD_CLR_ALL: begin
              state_d     = ST_FILL;
              fill_addr_d = '0;
              fill_last_d = AW'(CELLS - 1);
              fill_val_d  = CH_EMPTY;
            end
            CMD_CLR_BOT: begin
              state_d     = ST_FILL;
              fill_addr_d = cur_addr;
              fill_last_d = AW'(CELLS - 1);
              fill_val_d  = CH_EMPTY;
            end
            CMD_READ: begin
              mem_re  = 1'b1;
              state_d = ST_READ;
            end
            default: begin
              done_now = 1'b1;
            end
          endcase
        end
      end

      ST_FILL: begin
        mem_we = 1'b1;
        if (fill_addr_q == fill_last_q) begin
          done_now = 1'b1;
        end else begin
          fill_addr_d = fill_addr_q + AW'(1);
        end
      end

      ST_READ: begin
        out_val    = rd_data_q;
        pend_val_d = rd_data_q;
        done_now   = 1'b1;
      end

      ST_DONE: begin
        done_now = 1'b1;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A finished command either leaves through the output register right
    // away or parks until the output register has room.
    out_load = 1'b0;
    if (done_now) begin
      if (out_free) begin
        out_load = 1'b1;
        state_d  = ST_IDLE;
      end else begin
        state_d  = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      fill_addr_q <= '0;
      fill_last_q <= AW'(CELLS - 1);
      fill_val_q  <= CH_EMPTY;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      fill_addr_q <= fill_addr_d;
      fill_last_q <= fill_last_d;
      fill_val_q  <= fill_val_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; loaded with the cursor as it stands after the command.
  always_ff @(posedge clk_i) begin
    pend_val_q <= pend_val_d;
    if (out_load) begin
      out_row_q  <= ROW_W'(cur_row_d);
      out_col_q  <= COL_W'(cur_col_d);
      out_cell_q <= out_val;
    end
  end

  // Cell store: one write and one registered read per cycle. Writes happen
  // only in the reset sweep or a fill run and reads only when a command is taken,
  // so a read never meets a write in flight.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[fill_addr_q] <= fill_val_q;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DW - ROW_W - COL_W - CHAR_W){1'b0}},
                          out_cell_q, out_col_q, out_row_q};

  // The cursor never leaves the screen.
  a_cursor_on_screen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cur_row_q) < 32'(ROWS)) && (32'(cur_col_q) < 32'(COLUMNS)))
    else $error("cursor left the screen");

  // A fill run never walks past its last cell.
  a_fill_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL || state_q == ST_INIT) |->
      (fill_addr_q <= fill_last_q) && (32'(fill_last_q) < 32'(CELLS)))
    else $error("fill address beyond its run");

  // Read data is only consumed in the cycle after a read command was taken.
  a_read_follows_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> ($past(s_fire) && $past(in_cmd) == CMD_READ))
    else $error("read state without a read command");

  // No command is taken while the store is still being cleared after reset.
  a_no_accept_in_init : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> !s_fire && !out_load)
    else $error("activity during the clearing sweep");

endmodule : text_screen_cell_writer
`default_nettype wire

@@ tb/sv/tscw_screen_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscw_screen_checker: result checker for the text screen cell writer
// Watches both stream channels. Every accepted command word updates a private
// copy of the cell store and cursor and queues the report it should produce;
// every accepted result word is compared against the oldest queued report.
// ----------------------------------------------------------------------------
module tscw_screen_checker
  import tscw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  input  wire logic              s_axis_tready,
  // tdata: char_code [7:0], row [12:8], column [19:13], zero fill above.
  input  wire logic [IN_DW-1:0]  s_axis_tdata,
  // tuser: command [2:0].
  input  wire logic [CMD_W-1:0]  s_axis_tuser,
  input  wire logic              m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // tdata: cursor_row_out [4:0], cursor_column_out [11:5], cell_value [19:12].
  input  wire logic [OUT_DW-1:0] m_axis_tdata,
  output int                     mismatches_o,
  output int                     pending_o,
  output int                     checked_o
);

  localparam int unsigned CELLS     = ROWS * COLUMNS;
  localparam int unsigned REPORT_W  = ROW_W + COL_W + CHAR_W;
  localparam int unsigned MAX_SHOWN = 10;

  // Declared from the top bit down, so the row lands in the lowest bits.
  typedef struct packed {
    logic [CHAR_W-1:0] cell_val;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } cursor_report_t;

  logic [CHAR_W-1:0] screen_mirror [CELLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  cursor_report_t    expected_reports [$];
  int                mismatch_total;
  int                checked_total;

  // Carries out one command on the private store and cursor.
  function automatic cursor_report_t execute_command(
    input logic [CMD_W-1:0]  op,
    input logic [CHAR_W-1:0] ch,
    input logic [ROW_W-1:0]  r,
    input logic [COL_W-1:0]  c
  );
    cursor_report_t    report;
    logic [CHAR_W-1:0] value;
    int unsigned       span;
    int unsigned       room;
    int unsigned       tr;
    int unsigned       tc;
    value = CH_EMPTY;
    tr = (r >= ROWS) ? ROWS - 1 : r;
    tc = (c >= COLUMNS) ? COLUMNS - 1 : c;
    case (op)
      CMD_PUT: begin
        if (ch == CH_NEWLINE) begin
          for (int unsigned i = cur_col; i < COLUMNS; i++)
            screen_mirror[cur_row * COLUMNS + i] = CH_EMPTY;
          if (cur_row + 1 < ROWS) begin
            cur_row++;
            cur_col = 0;
          end
        end else if (ch == CH_TAB) begin
          span = TAB_STEP - (cur_col % TAB_STEP);
          room = COLUMNS - cur_col;
          if (span > room)
            span = room;
          for (int unsigned i = 0; i < span; i++)
            screen_mirror[cur_row * COLUMNS + cur_col + i] = CH_SPACE;
          cur_col += span;
          // The bottom row keeps the cursor on its last column.
          if (cur_col >= COLUMNS) begin
            if (cur_row + 1 < ROWS) begin
              cur_row++;
              cur_col = 0;
            end else begin
              cur_col = COLUMNS - 1;
            end
          end
        end else begin
          screen_mirror[cur_row * COLUMNS + cur_col] = ch;
          if (cur_col + 1 >= COLUMNS) begin
            if (cur_row + 1 < ROWS) begin
              cur_row++;
              cur_col = 0;
            end
          end else begin
            cur_col++;
          end
        end
      end
      CMD_MOVE: begin
        cur_row = tr;
        cur_col = tc;
      end
      CMD_CLR_ALL: begin
        for (int unsigned i = 0; i < CELLS; i++)
          screen_mirror[i] = CH_EMPTY;
      end
      CMD_CLR_BOT: begin
        for (int unsigned i = cur_row * COLUMNS + cur_col; i < CELLS; i++)
          screen_mirror[i] = CH_EMPTY;
      end
      CMD_READ: begin
        value = screen_mirror[tr * COLUMNS + tc];
      end
      default: begin
      end
    endcase
    report.row      = ROW_W'(cur_row);
    report.col      = COL_W'(cur_col);
    report.cell_val = value;
    return report;
  endfunction

  task automatic log_mismatch(
    input string          why,
    input cursor_report_t want,
    input cursor_report_t seen
  );
    mismatch_total++;
    if (mismatch_total <= MAX_SHOWN)
      $display("%0t: %s: expected row %0d col %0d cell %02h, got row %0d col %0d cell %02h",
               $realtime, why, want.row, want.col, want.cell_val,
               seen.row, seen.col, seen.cell_val);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cursor_report_t want;
    cursor_report_t seen;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < CELLS; i++)
        screen_mirror[i] = CH_EMPTY;
      cur_row = 0;
      cur_col = 0;
      expected_reports.delete();
      pending_o <= 0;
    end else begin
      // A result accepted on this edge belongs to an earlier command, so it is
      // matched before this edge's command is queued.
      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata[REPORT_W-1:0];
        checked_total++;
        if (expected_reports.size() == 0) begin
          log_mismatch("result word with nothing outstanding", '0, seen);
        end else begin
          want = expected_reports.pop_front();
          if (seen.row !== want.row || seen.col !== want.col ||
              seen.cell_val !== want.cell_val)
            log_mismatch("result word mismatch", want, seen);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_reports.push_back(execute_command(s_axis_tuser, s_axis_tdata[7:0],
                                                   s_axis_tdata[12:8],
                                                   s_axis_tdata[19:13]));
      pending_o    <= expected_reports.size();
      mismatches_o <= mismatch_total;
      checked_o    <= checked_total;
    end
  end

endmodule : tscw_screen_checker

@@ tb/sv/tb_text_screen_cell_writer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_screen_cell_writer: stimulus and verdict for the cell writer
// Sends a directed set of command words covering cursor wrap, hold and clamp
// corners, then random text-like traffic under several pacing phases. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_text_screen_cell_writer;
  import tscw_pkg::*;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;

  // Command codes the block treats as no-ops.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  // Some printable characters for the directed part.
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LOWER_Q = 8'h71;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CHAR_W-1:0] CH_ALL_ONE = 8'hff;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7e;

  localparam int unsigned PHASES      = 4;
  localparam int unsigned PHASE_WORDS = 456;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // tdata: char_code [7:0], row [12:8], column [19:13], zero fill above.
  logic [IN_DW-1:0]  s_axis_tdata = '0;
  // tuser: command [2:0].
  logic [CMD_W-1:0]  s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // tdata: cursor_row_out [4:0], cursor_column_out [11:5], cell_value [19:12].
  logic [OUT_DW-1:0] m_axis_tdata;

  int mismatch_count;
  int results_pending;
  int results_checked;

  // Pacing knobs, in percent of cycles.
  int unsigned send_gap_pct  = 0;
  int unsigned sink_stall_pct = 0;

  // Tallies of what was sent, for the closing summary.
  int n_chars, n_newlines, n_tabs, n_moves, n_clears, n_reads, n_spare;

  always #4 clk_i = ~clk_i;

  text_screen_cell_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tscw_screen_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches_o  (mismatch_count),
    .pending_o     (results_pending),
    .checked_o     (results_checked)
  );

  // The result side draws a fresh ready every cycle, so stalls can meet any
  // result word, including the one that ends a long clearing walk.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Offers one command word and returns on the edge that accepts it. Idle
  // cycles in front of the word come from send_gap_pct.
  task automatic send_word(
    input logic [CMD_W-1:0]  op,
    input logic [CHAR_W-1:0] ch,
    input logic [ROW_W-1:0]  r,
    input logic [COL_W-1:0]  c
  );
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_DW - COL_W - ROW_W - CHAR_W){1'b0}}, c, r, ch};
    case (op)
      CMD_PUT: begin
        if (ch == CH_NEWLINE)
          n_newlines++;
        else if (ch == CH_TAB)
          n_tabs++;
        else
          n_chars++;
      end
      CMD_MOVE:                n_moves++;
      CMD_CLR_ALL, CMD_CLR_BOT: n_clears++;
      CMD_READ:                n_reads++;
      default:                 n_spare++;
    endcase
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Holds the command side idle until every outstanding result has come
  // back, or until the cycle budget runs out. The first edge is always
  // waited so that a word accepted just before is counted.
  task automatic wait_results_drained(input int unsigned max_cycles);
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (results_pending != 0 && waited < max_cycles);
  endtask

  // One random word. Most traffic looks like text being typed: printable
  // characters with newlines and tabs mixed in, cursor jumps and reads back.
  // A small share is clears, out-of-range moves and reads, and spare codes.
  task automatic send_random_word();
    logic [CMD_W-1:0]  op;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  r;
    logic [COL_W-1:0]  c;
    int unsigned       pick;
    int unsigned       sel;
    pick = $urandom_range(999);
    sel  = $urandom_range(99);
    ch   = CHAR_W'($urandom_range(255));
    r    = ROW_W'($urandom_range(31));
    c    = COL_W'($urandom_range(127));
    if (pick < 600) begin
      op = CMD_PUT;
      if (sel < 72)
        ch = CHAR_W'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
      else if (sel < 82)
        ch = CH_NEWLINE;
      else if (sel < 90)
        ch = CH_TAB;
    end else if (pick < 760) begin
      op = CMD_READ;
      if (sel < 80) begin
        r = ROW_W'($urandom_range(ROWS - 1));
        c = COL_W'($urandom_range(COLUMNS - 1));
      end
    end else if (pick < 940) begin
      op = CMD_MOVE;
      // Jumps near the bottom right corner exercise the hold behavior.
      if (sel < 60) begin
        r = ROW_W'($urandom_range(ROWS - 1));
        c = COL_W'($urandom_range(COLUMNS - 1));
      end else if (sel < 80) begin
        r = ROW_W'(ROWS - 1);
        c = COL_W'($urandom_range(COLUMNS - 1, COLUMNS - 10));
      end
    end else if (pick < 950) begin
      op = CMD_CLR_ALL;
    end else if (pick < 965) begin
      op = CMD_CLR_BOT;
    end else if (pick < 985) begin
      op = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    end else begin
      op = CMD_PUT;
    end
    send_word(op, ch, r, c);
  endtask

  initial begin : stimulus
    int unsigned gap_by_phase   [PHASES];
    int unsigned stall_by_phase [PHASES];
    // Phase 0 runs flat out, then the sender gaps, then the receiver stalls,
    // then both at a lighter rate.
    gap_by_phase   = '{0, 82, 0, 32};
    stall_by_phase = '{0, 0, 82, 32};
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The block sweeps its store after reset and holds off the
    // first word until that is done; the handshake simply waits it out.
    send_word(CMD_READ, CH_EMPTY, '0, '0);            // store starts empty
    send_word(CMD_PUT, CH_UPPER_A, '0, '0);
    send_word(CMD_PUT, CH_ALL_ONE, '1, '1);
    send_word(CMD_PUT, CH_EMPTY, '0, '0);             // code zero leaves the cell empty
    send_word(CMD_PUT, CH_TAB, '0, '0);               // column 3 to the stop at 8
    send_word(CMD_PUT, CH_LOWER_X, '0, '0);
    send_word(CMD_READ, CH_EMPTY, 5'd0, 7'd1);
    send_word(CMD_PUT, CH_NEWLINE, '0, '0);           // rest of row 0 cleared
    send_word(CMD_MOVE, CH_EMPTY, 5'd3, 7'd77);
    send_word(CMD_PUT, CH_TAB, '0, '0);               // tab runs into the row end and wraps
    send_word(CMD_MOVE, CH_EMPTY, 5'd5, 7'd79);
    send_word(CMD_PUT, CH_LOWER_Q, '0, '0);           // last column wraps to the next row
    send_word(CMD_MOVE, CH_EMPTY, '1, '1);            // clamped to the bottom right cell
    send_word(CMD_PUT, CH_UPPER_Z, '0, '0);           // bottom right: written, cursor holds
    send_word(CMD_PUT, CH_NEWLINE, '0, '0);           // newline on the bottom row stays put
    send_word(CMD_MOVE, CH_EMPTY, 5'd24, 7'd75);
    send_word(CMD_PUT, CH_TAB, '0, '0);               // tab on the bottom row holds at the end
    send_word(CMD_READ, CH_EMPTY, '1, '1);            // read clamps to the bottom right cell
    send_word(CMD_MOVE, CH_EMPTY, 5'd0, 7'd2);
    send_word(CMD_CLR_BOT, CH_EMPTY, '0, '0);
    send_word(CMD_READ, CH_EMPTY, 5'd0, 7'd0);        // before the cursor, kept
    send_word(CMD_READ, CH_EMPTY, 5'd0, 7'd8);        // after it, cleared
    for (int unsigned k = CMD_SPARE_FIRST; k <= CMD_SPARE_LAST; k++)
      send_word(CMD_W'(k), CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
    send_word(CMD_CLR_ALL, CH_EMPTY, '0, '0);
    send_word(CMD_READ, CH_EMPTY, 5'd0, 7'd0);
    wait_results_drained(1_000_000);

    // Random part, one pacing setting per phase. Between phases the sender
    // holds back until every result has arrived.
    for (int unsigned p = 0; p < PHASES; p++) begin
      send_gap_pct   = gap_by_phase[p];
      sink_stall_pct = stall_by_phase[p];
      for (int unsigned n = 0; n < PHASE_WORDS; n++)
        send_random_word();
      wait_results_drained(1_000_000);
    end

    // Let the last results out with the result side running freely, then
    // give the block time to show any stray extra word.
    sink_stall_pct = 0;
    wait_results_drained(200_000);
    repeat (64) @(posedge clk_i);

    $display("Covered %0d characters, %0d newlines, %0d tabs, %0d moves, %0d clears, %0d reads",
             n_chars, n_newlines, n_tabs, n_moves, n_clears, n_reads);
    $display("and %0d spare codes; %0d results checked under four pacing phases.",
             n_spare, results_checked);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("tb_text_screen_cell_writer OK");
    end else begin
      $display("tb_text_screen_cell_writer NOT OK");
    end
    $finish;
  end

  // Watchdog far beyond any correct run, clears and stalls included.
  initial begin : watchdog
    #250_000_000;
    $display("Timeout with %0d results outstanding.", results_pending);
    $display("tb_text_screen_cell_writer NOT OK");
    $finish;
  end

endmodule : tb_text_screen_cell_writer
